@@ hw/rtl/i2cbl_pkg.sv @@
// Shared types and codes for the I2C bit-level master line sequencer.
package i2cbl_pkg;

    // Command codes as they arrive on the input stream.
    localparam logic [2:0] MODE_START     = 3'd0;
    localparam logic [2:0] MODE_STOP      = 3'd1;
    localparam logic [2:0] MODE_SEND_BYTE = 3'd2;
    localparam logic [2:0] MODE_RECV_BYTE = 3'd3;
    localparam logic [2:0] MODE_SEND_ACK  = 3'd4;
    localparam logic [2:0] MODE_RECV_ACK  = 3'd5;

    // Line action codes on the output stream.
    localparam logic [1:0] ACT_SCL    = 2'd0;
    localparam logic [1:0] ACT_SDA    = 2'd1;
    localparam logic [1:0] ACT_SAMPLE = 2'd2;

    // Index of the last bit of a byte.
    localparam logic [2:0] LAST_BIT = 3'd7;

    // Decoded command kind.
    typedef enum logic [5:0] {
        K_START     = 6'b000001,
        K_STOP      = 6'b000010,
        K_SEND_BYTE = 6'b000100,
        K_RECV_BYTE = 6'b001000,
        K_SEND_ACK  = 6'b010000,
        K_RECV_ACK  = 6'b100000
    } cmd_kind_t;

    // One queued command: the byte is tx_byte for send byte, sda_samples otherwise.
    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data;
        logic       ack_bit;
    } cmd_t;

    // Head of the command queue as seen by the sequencer.
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_head_t;

endpackage

@@ hw/rtl/i2cbl_front.sv @@
// Command front end: accepts, classifies and queues commands.
module i2cbl_front
    import i2cbl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [2:0]  s_tuser,
    input  logic [23:0] s_tdata,
    output q_head_t     head,
    input  logic        pop
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    cmd_t       in_cmd;
    logic       keep;
    logic       push;

    // Decode the mode; unused modes are accepted and dropped.
    always_comb
    begin
        in_cmd.kind    = K_START;
        in_cmd.data    = s_tdata[16:9];
        in_cmd.ack_bit = s_tdata[8];
        keep           = 1'b1;
        case (s_tuser)
            MODE_START:     in_cmd.kind = K_START;
            MODE_STOP:      in_cmd.kind = K_STOP;
            MODE_SEND_BYTE:
            begin
                in_cmd.kind = K_SEND_BYTE;
                in_cmd.data = s_tdata[7:0];
            end
            MODE_RECV_BYTE: in_cmd.kind = K_RECV_BYTE;
            MODE_SEND_ACK:  in_cmd.kind = K_SEND_ACK;
            MODE_RECV_ACK:  in_cmd.kind = K_RECV_ACK;
            default:        keep = 1'b0;
        endcase
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready && keep;

    // Queue pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    assign head.valid = (cnt_reg != 2'd0);
    assign head.cmd   = entry_reg[rd_ptr_reg];

endmodule

@@ hw/rtl/i2cbl_back.sv @@
// Line sequencer: steps through the actions of the queued command.
module i2cbl_back
    import i2cbl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  q_head_t    head,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [1:0] act,
    output logic       level,
    output logic [7:0] rx_byte,
    output logic       ack_in,
    output logic       m_tlast
);

    logic [1:0] phase_reg, phase_next;
    logic [2:0] bit_reg, bit_next;
    logic       out_valid_reg;
    logic [1:0] act_reg;
    logic       level_reg;
    logic [7:0] rx_reg;
    logic       ack_reg;
    logic       last_reg;

    logic [1:0] cur_act;
    logic       cur_lvl;
    logic       fin;
    logic       load;
    logic       cur_bit;

    assign load    = head.valid && (!out_valid_reg || m_tready);
    assign cur_bit = head.cmd.data[LAST_BIT - bit_reg];

    // Action for the current step of the command.
    always_comb
    begin
        cur_act    = ACT_SCL;
        cur_lvl    = 1'b0;
        fin        = 1'b0;
        phase_next = phase_reg + 2'd1;
        bit_next   = bit_reg;
        case (head.cmd.kind)
            K_START:
            begin
                cur_act = phase_reg[0] ? ACT_SCL : ACT_SDA;
                cur_lvl = ~phase_reg[1];
                fin     = (phase_reg == 2'd3);
            end
            K_STOP:
            begin
                cur_act = (phase_reg == 2'd1) ? ACT_SCL : ACT_SDA;
                cur_lvl = (phase_reg != 2'd0);
                fin     = (phase_reg == 2'd2);
            end
            K_SEND_BYTE:
            begin
                cur_act = (phase_reg == 2'd0) ? ACT_SDA : ACT_SCL;
                cur_lvl = (phase_reg == 2'd0) ? cur_bit : (phase_reg == 2'd1);
                if (phase_reg == 2'd2)
                begin
                    fin        = (bit_reg == LAST_BIT);
                    phase_next = 2'd0;
                    bit_next   = bit_reg + 3'd1;
                end
            end
            K_RECV_BYTE:
            begin
                // The release of SDA happens once, then SCL high, sample, SCL low per bit.
                case (phase_reg)
                    2'd0:
                    begin
                        cur_act = ACT_SDA;
                        cur_lvl = 1'b1;
                    end
                    2'd1:
                    begin
                        cur_act = ACT_SCL;
                        cur_lvl = 1'b1;
                    end
                    2'd2:
                    begin
                        cur_act = ACT_SAMPLE;
                        cur_lvl = cur_bit;
                    end
                    default:
                    begin
                        cur_act    = ACT_SCL;
                        cur_lvl    = 1'b0;
                        fin        = (bit_reg == LAST_BIT);
                        phase_next = 2'd1;
                        bit_next   = bit_reg + 3'd1;
                    end
                endcase
            end
            K_SEND_ACK:
            begin
                cur_act = (phase_reg == 2'd0) ? ACT_SDA : ACT_SCL;
                cur_lvl = (phase_reg == 2'd0) ? head.cmd.ack_bit : (phase_reg == 2'd1);
                fin     = (phase_reg == 2'd2);
            end
            K_RECV_ACK:
            begin
                case (phase_reg)
                    2'd0:    cur_act = ACT_SDA;
                    2'd2:    cur_act = ACT_SAMPLE;
                    default: cur_act = ACT_SCL;
                endcase
                cur_lvl = (phase_reg == 2'd2) ? head.cmd.data[7] : (phase_reg != 2'd3);
                fin     = (phase_reg == 2'd3);
            end
            default:
            begin
                fin = 1'b1;
            end
        endcase
        if (fin)
        begin
            phase_next = 2'd0;
            bit_next   = 3'd0;
        end
    end

    assign pop = load && fin;

    // Step counters and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 2'd0;
            bit_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                phase_reg     <= phase_next;
                bit_reg       <= bit_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            act_reg   <= cur_act;
            level_reg <= cur_lvl;
            rx_reg    <= (fin && head.cmd.kind == K_RECV_BYTE) ? head.cmd.data : 8'd0;
            ack_reg   <= fin && (head.cmd.kind == K_RECV_ACK) && head.cmd.data[7];
            last_reg  <= fin;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign act      = act_reg;
    assign level    = level_reg;
    assign rx_byte  = rx_reg;
    assign ack_in   = ack_reg;
    assign m_tlast  = last_reg;

endmodule

@@ hw/rtl/i2c_bit_level_master.sv @@
// Top level of the I2C bit-level master line sequencer.
//
// Channel  Dir  Width             Contents
// s_*      in   tuser 3, data 24  command transfer: mode, tx_byte, ack_out, sda_samples
// m_*      out  tuser 2, data 16  line action transfer: action, level, rx_byte, ack_in, last
//
// A command produces as many line actions as its kind has: 4 start, 3 stop, 24 send byte,
// 25 receive byte, 3 send ack, 4 receive ack; the sequencer emits one action per cycle
// while the sink does not stall. Unused modes are accepted and produce nothing.
// A two-entry command queue lets new commands enter while the sequencer is busy, and the
// output register holds an action while the sink stalls.
// Reset clears the queue, the step counters and the output valid.
module i2c_bit_level_master
    import i2cbl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [2:0]  s_tuser,   // mode
    input  logic [23:0] s_tdata,   // tx_byte[7:0], ack_out[8], sda_samples[16:9], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [1:0]  m_tuser,   // action
    output logic [15:0] m_tdata,   // level[0], rx_byte[8:1], ack_in[9], zero pad
    output logic        m_tlast
);

    q_head_t    head;
    logic       pop;
    logic       level;
    logic [7:0] rx_byte;
    logic       ack_in;

    // Front end and command queue.
    i2cbl_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .head     (head),
        .pop      (pop)
    );

    // Line sequencer.
    i2cbl_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .act      (m_tuser),
        .level    (level),
        .rx_byte  (rx_byte),
        .ack_in   (ack_in),
        .m_tlast  (m_tlast)
    );

    assign m_tdata = {6'd0, ack_in, rx_byte, level};

`ifndef SYNTHESIS
    // A full queue always presents a command to the sequencer.
    assert property (@(posedge clk) disable iff (!rst_n) !s_tready |-> head.valid)
        else $error("queue full without a head command");

    // Received data is reported only on the last action of a command.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> (m_tdata[9:1] == 9'd0))
        else $error("receive data outside the last action");

    // Only defined line actions appear.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser != 2'd3))
        else $error("undefined line action");

    // A set ack bit appears only on the final SCL low action of a command.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[9]) |-> (m_tlast && m_tuser == ACT_SCL))
        else $error("ack reported off the final SCL low action");
`endif

endmodule

@@ tb/i2c_bit_level_master_tb.sv @@
// Testbench for the I2C bit-level master line sequencer: directed and random commands.
module i2c_bit_level_master_tb
    import i2cbl_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD = 12;
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_COMMANDS = 350;
    localparam int HOLD_AT_ACTION = 300;
    localparam int HOLD_CYCLES = 500;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT = 300000;

    // Mode codes the block does not implement.
    localparam logic [2:0] MODE_UNUSED_LO = 3'd6;
    localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

    // One line action as it appears on the output stream.
    typedef struct packed {
        logic [1:0] action;
        logic       level;
        logic [7:0] rx_byte;
        logic       ack_in;
        logic       last;
    } line_action_t;

    // Predicts the line actions of each accepted command and checks them in order.
    class line_action_checker;
        line_action_t expected_actions[$];
        logic         scl_level;
        logic         sda_level;
        int           errors;

        function new();
            scl_level = 1'b1;
            sda_level = 1'b1;
            errors = 0;
        endfunction

        function void emit(logic [1:0] act, logic lvl);
            line_action_t a;
            a.action = act;
            a.level = lvl;
            a.rx_byte = 8'd0;
            a.ack_in = 1'b0;
            a.last = 1'b0;
            if (act == ACT_SCL) scl_level = lvl;
            if (act == ACT_SDA) sda_level = lvl;
            expected_actions.push_back(a);
        endfunction

        // Expand one accepted command into its line actions.
        function void note_command(logic [2:0] mode, logic [7:0] tx, logic ack,
                                   logic [7:0] samples);
            logic [7:0] rx;
            int         last_idx;
            rx = 8'd0;
            case (mode)
                MODE_START:
                begin
                    emit(ACT_SDA, 1'b1);
                    emit(ACT_SCL, 1'b1);
                    emit(ACT_SDA, 1'b0);
                    emit(ACT_SCL, 1'b0);
                end
                MODE_STOP:
                begin
                    emit(ACT_SDA, 1'b0);
                    emit(ACT_SCL, 1'b1);
                    emit(ACT_SDA, 1'b1);
                end
                MODE_SEND_BYTE:
                begin
                    for (int i = 7; i >= 0; i--)
                    begin
                        emit(ACT_SDA, tx[i]);
                        emit(ACT_SCL, 1'b1);
                        emit(ACT_SCL, 1'b0);
                    end
                end
                MODE_RECV_BYTE:
                begin
                    emit(ACT_SDA, 1'b1);
                    for (int i = 7; i >= 0; i--)
                    begin
                        rx[i] = samples[i];
                        emit(ACT_SCL, 1'b1);
                        emit(ACT_SAMPLE, samples[i]);
                        emit(ACT_SCL, 1'b0);
                    end
                end
                MODE_SEND_ACK:
                begin
                    emit(ACT_SDA, ack);
                    emit(ACT_SCL, 1'b1);
                    emit(ACT_SCL, 1'b0);
                end
                MODE_RECV_ACK:
                begin
                    emit(ACT_SDA, 1'b1);
                    emit(ACT_SCL, 1'b1);
                    emit(ACT_SAMPLE, samples[7]);
                    emit(ACT_SCL, 1'b0);
                end
                default:
                    // Unused modes produce nothing and leave the lines alone.
                    return;
            endcase
            last_idx = expected_actions.size() - 1;
            expected_actions[last_idx].last = 1'b1;
            if (mode == MODE_RECV_BYTE) expected_actions[last_idx].rx_byte = rx;
            if (mode == MODE_RECV_ACK) expected_actions[last_idx].ack_in = samples[7];
        endfunction

        function void report(string field, int want, int got);
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            errors++;
        endfunction

        // Compare one accepted output transfer with the oldest expectation.
        function void check_action(logic [1:0] act, logic [15:0] data, logic last);
            line_action_t want;
            if (expected_actions.size() == 0)
            begin
                $display("%0t ns: unexpected action, expected none, actual action %0h data %0h",
                         $time, act, data);
                errors++;
                return;
            end
            want = expected_actions.pop_front();
            if (act !== want.action) report("action", want.action, act);
            if (data[0] !== want.level) report("level", want.level, data[0]);
            if (data[8:1] !== want.rx_byte) report("rx_byte", want.rx_byte, data[8:1]);
            if (data[9] !== want.ack_in) report("ack_in", want.ack_in, data[9]);
            if (last !== want.last) report("last", want.last, last);
        endfunction

        function int pending();
            return expected_actions.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [2:0]  s_tuser;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [1:0]  m_tuser;
    logic [15:0] m_tdata;
    logic        m_tlast;

    line_action_checker board;
    int  commands_sent;
    int  actions_seen;
    int  cycle_count;
    bit  burst;
    bit  hold_done;

    i2c_bit_level_master DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Offer one command and wait until the block takes the transfer.
    task automatic send_command(input logic [2:0] mode, input logic [7:0] tx,
                                input logic ack, input logic [7:0] samples);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= {7'd0, samples, ack, tx};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        board.note_command(mode, tx, ack, samples);
        if (mode <= MODE_RECV_ACK) commands_sent++;
    endtask

    // Command with random content in every field.
    task automatic send_random(input logic [2:0] mode);
        send_command(mode, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                     8'($urandom_range(0, 255)));
    endtask

    // One bus transaction: address, then a run of data bytes, then usually a stop.
    task automatic send_transaction();
        int  count;
        bit  is_read;
        count = $urandom_range(1, 6);
        is_read = $urandom_range(0, 1);
        send_random(MODE_START);
        send_random(MODE_SEND_BYTE);
        send_random(MODE_RECV_ACK);
        for (int i = 0; i < count; i++)
        begin
            if (is_read)
            begin
                send_random(MODE_RECV_BYTE);
                send_random(MODE_SEND_ACK);
            end
            else
            begin
                send_random(MODE_SEND_BYTE);
                send_random(MODE_RECV_ACK);
            end
        end
        // Now and then the stop is dropped to leave a broken sequence.
        if ($urandom_range(0, 7) != 0) send_random(MODE_STOP);
    endtask

    // Output side: random stalls, and one long hold-off to fill the block.
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            stall = burst ? 0 : $urandom_range(0, 4);
            if (!hold_done && actions_seen >= HOLD_AT_ACTION)
            begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
            board.check_action(m_tuser, m_tdata, m_tlast);
            actions_seen++;
        end
    end

    // Watchdog on the whole run.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("i2c_bit_level_master verification failed");
        $finish;
    end

    // Reset, directed commands, random transactions, then drain and verdict.
    initial
    begin
        board = new();
        commands_sent = 0;
        actions_seen = 0;
        burst = 1'b0;
        hold_done = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = '0;
        s_tdata = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every mode, byte extremes, both ack levels, unused modes.
        send_command(MODE_START, 8'h00, 1'b0, 8'h00);
        send_command(MODE_SEND_BYTE, 8'h00, 1'b1, 8'hFF);
        send_command(MODE_RECV_ACK, 8'hFF, 1'b1, 8'h00);
        send_command(MODE_SEND_BYTE, 8'hFF, 1'b0, 8'h00);
        send_command(MODE_RECV_ACK, 8'h00, 1'b0, 8'hFF);
        send_command(MODE_SEND_BYTE, 8'hA5, 1'b0, 8'h5A);
        send_command(MODE_RECV_ACK, 8'h00, 1'b0, 8'h7F);
        send_command(MODE_RECV_ACK, 8'hFF, 1'b1, 8'h80);
        send_command(MODE_RECV_BYTE, 8'hFF, 1'b1, 8'h00);
        send_command(MODE_SEND_ACK, 8'hFF, 1'b0, 8'hFF);
        send_command(MODE_RECV_BYTE, 8'h00, 1'b0, 8'hFF);
        send_command(MODE_SEND_ACK, 8'h00, 1'b1, 8'h00);
        send_command(MODE_RECV_BYTE, 8'h3C, 1'b1, 8'h5A);
        send_command(MODE_UNUSED_LO, 8'hFF, 1'b1, 8'hFF);
        send_command(MODE_UNUSED_HI, 8'h00, 1'b0, 8'h00);
        send_command(MODE_STOP, 8'hFF, 1'b1, 8'hFF);
        send_command(MODE_STOP, 8'h00, 1'b0, 8'h00);
        send_command(MODE_START, 8'hFF, 1'b1, 8'hFF);
        send_command(MODE_START, 8'h00, 1'b0, 8'h00);
        send_command(MODE_UNUSED_HI, 8'hFF, 1'b1, 8'hFF);
        send_command(MODE_STOP, 8'h5A, 1'b0, 8'hA5);

        // Random: mostly well-formed transactions, some noise in between.
        while (commands_sent < RANDOM_COMMANDS)
        begin
            burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 7) == 0)
            begin
                repeat ($urandom_range(1, 3)) send_random(3'($urandom_range(0, 7)));
            end
            send_transaction();
        end
        burst = 1'b0;
        s_tvalid <= 1'b0;

        while (board.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.errors == 0)
            $display("i2c_bit_level_master verification clean");
        else
            $display("i2c_bit_level_master verification failed");
        $finish;
    end

endmodule
